FILE: design/dbw_pkg.sv
package dbw_pkg;

  localparam int SLOT_W = 4;
  localparam int SEG_W  = 16;
  localparam int OFFS_W = 16;
  localparam int ADDR_W = 20;

  typedef enum logic [2:0] {
    OP_ADD_BP    = 3'd0,
    OP_REM_BP    = 3'd1,
    OP_CLR_BP    = 3'd2,
    OP_ADD_WP    = 3'd3,
    OP_REM_WP    = 3'd4,
    OP_CLR_WP    = 3'd5,
    OP_CHK_ACC   = 3'd6,
    OP_CHK_FETCH = 3'd7
  } op_e;

  localparam logic REASON_BP = 1'b0;
  localparam logic REASON_WP = 1'b1;

  // Command word handed from the front end to the execution side.
  typedef struct packed {
    op_e                kind;
    logic [SEG_W-1:0]   seg;
    logic [OFFS_W-1:0]  offs;
    logic [ADDR_W-1:0]  address;
    logic [ADDR_W-1:0]  end_address;
    logic               on_read;
    logic               trig_wr;
    logic               acc_wr;
    logic [SLOT_W-1:0]  slot_index;
    logic               wp_args_ok;
    logic               fetch_en;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic               reason;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  address;
    logic [SEG_W-1:0]   segment;
    logic [OFFS_W-1:0]  offset;
    logic               acc_wr;
  } rec_t;

  typedef struct packed {
    logic               ok;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    rec_t               rec;
  } res_t;

endpackage

FILE: design/dbw_fifo.sv
module dbw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/dbw_front.sv
module dbw_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [2:0]                 op_i,
  input  logic [dbw_pkg::SEG_W-1:0]  seg_i,
  input  logic [dbw_pkg::OFFS_W-1:0] offs_i,
  input  logic [dbw_pkg::ADDR_W-1:0] address_i,
  input  logic [dbw_pkg::ADDR_W-1:0] end_address_i,
  input  logic                       on_read_i,
  input  logic                       trig_wr_i,
  input  logic                       acc_wr_i,
  input  logic [dbw_pkg::SLOT_W-1:0] slot_index_i,
  input  logic                       cpu_halted_i,
  output logic                       cmd_push_o,
  output dbw_pkg::cmd_t              cmd_o,
  input  logic                       cmd_full_i
);

  logic          valid_q, valid_d;
  dbw_pkg::cmd_t cmd_q, cmd_d;
  logic          accept;

  assign full       = valid_q && cmd_full_i;
  assign accept     = push && !full;
  assign cmd_push_o = valid_q;
  assign cmd_o      = cmd_q;

  // Decode the word and settle the argument checks that need no table state.
  always_comb begin
    cmd_d.kind        = dbw_pkg::op_e'(op_i);
    cmd_d.seg         = seg_i;
    cmd_d.offs        = offs_i;
    cmd_d.address     = address_i;
    cmd_d.end_address = end_address_i;
    cmd_d.on_read     = on_read_i;
    cmd_d.trig_wr     = trig_wr_i;
    cmd_d.acc_wr      = acc_wr_i;
    cmd_d.slot_index  = slot_index_i;
    cmd_d.wp_args_ok  = (address_i <= end_address_i) && (on_read_i || trig_wr_i);
    cmd_d.fetch_en    = !cpu_halted_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (valid_q && !cmd_full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

FILE: design/dbw_back.sv
module dbw_back #(
  parameter int NUM_BREAKPOINTS = 8,
  parameter int NUM_WATCHPOINTS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  dbw_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output dbw_pkg::res_t res_o
);

  localparam int NB = NUM_BREAKPOINTS;
  localparam int NW = NUM_WATCHPOINTS;
  localparam int SW = dbw_pkg::SLOT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]    state_q, state_d;
  dbw_pkg::cmd_t cmd_q;

  logic [NB-1:0] bp_en_q, bp_en_d;
  logic [dbw_pkg::SEG_W-1:0]  bp_seg_q  [NB];
  logic [dbw_pkg::OFFS_W-1:0] bp_offs_q [NB];
  logic [NW-1:0] wp_en_q, wp_en_d;
  logic [dbw_pkg::ADDR_W-1:0] wp_low_q  [NW];
  logic [dbw_pkg::ADDR_W-1:0] wp_high_q [NW];
  logic [NW-1:0] wp_rd_q, wp_wr_q;
  logic          skip_q, skip_d;
  dbw_pkg::rec_t rec_q, rec_d;

  logic [NB-1:0] bp_vec_q, bp_vec_d, bp_match, bp_dec, bp_lo, bp_wr;
  logic [NW-1:0] wp_vec_q, wp_vec_d, wp_match, wp_dec, wp_lo, wp_wr;
  logic [SW-1:0] bp_idx, wp_idx;
  logic          bp_any, wp_any;
  logic          commit;
  logic          ok, hit;
  logic [SW-1:0] slot;

  assign cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i;
  assign commit     = (state_q == ST_COMMIT) && !res_full_i;
  assign res_push_o = commit;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (!cmd_empty_i) state_d = ST_EVAL;
      ST_EVAL:   state_d = ST_COMMIT;
      ST_COMMIT: if (!res_full_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Evaluate state: compare every slot at once and keep the
  // candidate vector for the operation at hand.
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      bp_dec[i]   = (cmd_q.slot_index == SW'(i));
      bp_match[i] = bp_en_q[i] && (bp_seg_q[i] == cmd_q.seg) && (bp_offs_q[i] == cmd_q.offs);
    end
    for (int i = 0; i < NW; i++) begin
      wp_dec[i]   = (cmd_q.slot_index == SW'(i));
      wp_match[i] = wp_en_q[i] && (cmd_q.address >= wp_low_q[i]) &&
                    (cmd_q.address <= wp_high_q[i]) &&
                    (cmd_q.acc_wr ? wp_wr_q[i] : wp_rd_q[i]);
    end
    bp_vec_d = '0;
    wp_vec_d = '0;
    case (cmd_q.kind)
      dbw_pkg::OP_ADD_BP:    bp_vec_d = ~bp_en_q;
      dbw_pkg::OP_REM_BP:    bp_vec_d = bp_en_q & bp_dec;
      dbw_pkg::OP_CHK_FETCH: bp_vec_d = bp_match;
      dbw_pkg::OP_ADD_WP:    wp_vec_d = cmd_q.wp_args_ok ? ~wp_en_q : '0;
      dbw_pkg::OP_REM_WP:    wp_vec_d = wp_en_q & wp_dec;
      dbw_pkg::OP_CHK_ACC:   wp_vec_d = wp_match;
      default: ;
    endcase
  end

  // Commit state: pick the lowest candidate slot.
  always_comb begin
    bp_lo  = bp_vec_q & (~bp_vec_q + NB'(1));
    wp_lo  = wp_vec_q & (~wp_vec_q + NW'(1));
    bp_any = |bp_vec_q;
    wp_any = |wp_vec_q;
    bp_idx = '0;
    wp_idx = '0;
    for (int i = 0; i < NB; i++) begin
      if (bp_lo[i]) bp_idx = bp_idx | SW'(i);
    end
    for (int i = 0; i < NW; i++) begin
      if (wp_lo[i]) wp_idx = wp_idx | SW'(i);
    end
  end

  always_comb begin
    bp_en_d = bp_en_q;
    wp_en_d = wp_en_q;
    skip_d  = skip_q;
    rec_d   = rec_q;
    ok      = 1'b0;
    hit     = 1'b0;
    slot    = '0;
    case (cmd_q.kind)
      dbw_pkg::OP_ADD_BP: begin
        if (bp_any) begin
          ok      = 1'b1;
          slot    = bp_idx;
          bp_en_d = bp_en_q | bp_lo;
        end
      end
      dbw_pkg::OP_REM_BP: begin
        if (bp_any) begin
          ok      = 1'b1;
          bp_en_d = bp_en_q & ~bp_lo;
        end
      end
      dbw_pkg::OP_CLR_BP: begin
        ok      = 1'b1;
        bp_en_d = '0;
      end
      dbw_pkg::OP_ADD_WP: begin
        if (wp_any) begin
          ok      = 1'b1;
          slot    = wp_idx;
          wp_en_d = wp_en_q | wp_lo;
        end
      end
      dbw_pkg::OP_REM_WP: begin
        if (wp_any) begin
          ok      = 1'b1;
          wp_en_d = wp_en_q & ~wp_lo;
        end
      end
      dbw_pkg::OP_CLR_WP: begin
        ok      = 1'b1;
        wp_en_d = '0;
      end
      dbw_pkg::OP_CHK_ACC: begin
        if (wp_any) begin
          hit   = 1'b1;
          slot  = wp_idx;
          rec_d = '{valid: 1'b1, reason: dbw_pkg::REASON_WP, slot: wp_idx,
                    address: cmd_q.address, segment: cmd_q.seg,
                    offset: cmd_q.offs, acc_wr: cmd_q.acc_wr};
        end
      end
      dbw_pkg::OP_CHK_FETCH: begin
        // A fetch right after a breakpoint stop passes once unchecked.
        if (cmd_q.fetch_en && (|bp_en_q)) begin
          if (skip_q) begin
            skip_d = 1'b0;
          end else if (bp_any) begin
            hit    = 1'b1;
            slot   = bp_idx;
            skip_d = 1'b1;
            rec_d  = '{valid: 1'b1, reason: dbw_pkg::REASON_BP, slot: bp_idx,
                       address: '0, segment: cmd_q.seg,
                       offset: cmd_q.offs, acc_wr: 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.ok   = ok;
  assign res_o.hit  = hit;
  assign res_o.slot = slot;
  assign res_o.rec  = rec_d;

  assign bp_wr = (commit && (cmd_q.kind == dbw_pkg::OP_ADD_BP)) ? bp_lo : '0;
  assign wp_wr = (commit && (cmd_q.kind == dbw_pkg::OP_ADD_WP)) ? wp_lo : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bp_en_q <= '0;
      wp_en_q <= '0;
      skip_q  <= 1'b0;
      rec_q   <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        bp_en_q <= bp_en_d;
        wp_en_q <= wp_en_d;
        skip_q  <= skip_d;
        rec_q   <= rec_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_EVAL) begin
      bp_vec_q <= bp_vec_d;
      wp_vec_q <= wp_vec_d;
    end
    for (int i = 0; i < NB; i++) begin
      if (bp_wr[i]) begin
        bp_seg_q[i]  <= cmd_q.seg;
        bp_offs_q[i] <= cmd_q.offs;
      end
    end
    for (int i = 0; i < NW; i++) begin
      if (wp_wr[i]) begin
        wp_low_q[i]  <= cmd_q.address;
        wp_high_q[i] <= cmd_q.end_address;
        wp_rd_q[i]   <= cmd_q.on_read;
        wp_wr_q[i]   <= cmd_q.trig_wr;
      end
    end
  end

endmodule

FILE: design/debug_breakpoint_watchpoint_unit.sv
// Breakpoint and watchpoint comparator for a debug port.
// Both sides look like queues. A word is offered with push and taken at a
// rising edge where push is high and full is low. Each word gives exactly one
// result word, shown while empty is low and removed at an edge where pop is
// high and empty is low.
// The front end registers and decodes the word, then drops it into a
// two-word command queue. The execution side handles one word at a time,
// stepping through its idle, evaluate and commit states: pop from the queue,
// compare all slots in parallel, then pick the lowest matching slot, update
// the tables and the stop record, and write the result into a two-word
// result queue. It pops the next word only after the last result is written,
// while the front end can keep taking new words in the meantime.
// When pop stays low the result queue fills, the execution side waits in its
// commit state, then the command queue and the input register fill and full
// rises. Reset empties both queues, disables every slot and clears the stop
// record and the resume skip flag.
module debug_breakpoint_watchpoint_unit #(
  parameter int NUM_BREAKPOINTS = 8,
  parameter int NUM_WATCHPOINTS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [2:0]                 op_i,
  input  logic [dbw_pkg::SEG_W-1:0]  seg_i,
  input  logic [dbw_pkg::OFFS_W-1:0] offs_i,
  input  logic [dbw_pkg::ADDR_W-1:0] address_i,
  input  logic [dbw_pkg::ADDR_W-1:0] end_address_i,
  input  logic                       on_read_i,
  input  logic                       trig_wr_i,
  input  logic                       acc_wr_i,
  input  logic [dbw_pkg::SLOT_W-1:0] slot_index_i,
  input  logic                       cpu_halted_i,
  output logic                       empty,
  input  logic                       pop,
  output logic                       ok_o,
  output logic                       hit_o,
  output logic [dbw_pkg::SLOT_W-1:0] slot_o,
  output logic                       stop_valid_o,
  output logic                       stop_reason_o,
  output logic [dbw_pkg::SLOT_W-1:0] stop_slot_o,
  output logic [dbw_pkg::ADDR_W-1:0] stop_address_o,
  output logic [dbw_pkg::SEG_W-1:0]  stop_segment_o,
  output logic [dbw_pkg::OFFS_W-1:0] stop_offset_o,
  output logic                       stop_acc_wr_o
);

  dbw_pkg::cmd_t fe_cmd, be_cmd;
  dbw_pkg::res_t be_res, out_res;
  logic          fe_push, cmd_full, cmd_empty, cmd_pop;
  logic          res_push, res_full;

  dbw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .seg_i         (seg_i),
    .offs_i        (offs_i),
    .address_i     (address_i),
    .end_address_i (end_address_i),
    .on_read_i     (on_read_i),
    .trig_wr_i     (trig_wr_i),
    .acc_wr_i      (acc_wr_i),
    .slot_index_i  (slot_index_i),
    .cpu_halted_i  (cpu_halted_i),
    .cmd_push_o    (fe_push),
    .cmd_o         (fe_cmd),
    .cmd_full_i    (cmd_full)
  );

  dbw_fifo #(
    .WIDTH ($bits(dbw_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .data_i  (fe_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (be_cmd),
    .empty_o (cmd_empty)
  );

  dbw_back #(
    .NUM_BREAKPOINTS (NUM_BREAKPOINTS),
    .NUM_WATCHPOINTS (NUM_WATCHPOINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (be_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (be_res)
  );

  dbw_fifo #(
    .WIDTH ($bits(dbw_pkg::res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (be_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign ok_o           = out_res.ok;
  assign hit_o          = out_res.hit;
  assign slot_o         = out_res.slot;
  assign stop_valid_o   = out_res.rec.valid;
  assign stop_reason_o  = out_res.rec.reason;
  assign stop_slot_o    = out_res.rec.slot;
  assign stop_address_o = out_res.rec.address;
  assign stop_segment_o = out_res.rec.segment;
  assign stop_offset_o  = out_res.rec.offset;
  assign stop_acc_wr_o  = out_res.rec.acc_wr;

endmodule
